// ----- design/ggps_pkg.sv -----
// Shared widths, lane tables and square-root step for the grid path step unit.
`default_nettype none
package ggps_pkg;

	localparam int COORD_BITS = 10;
	localparam int FRAC_BITS  = 16;

	// Magnitude of one axis distance needs one bit more than a coordinate.
	localparam int MAG_W   = COORD_BITS + 1;
	localparam int DIFF_W  = COORD_BITS + 2;
	localparam int SUM_W   = 2 * COORD_BITS + 2;
	localparam int ROOT_W  = (SUM_W + 2 * FRAC_BITS) / 2;
	localparam int REM_W   = ROOT_W + 3;
	localparam int SCORE_W = ROOT_W + 1;
	localparam int LANES   = 8;
	localparam int LIDX_W  = 3;

	// Offset codes: 0 is -1, 1 is 0, 2 is +1.
	localparam logic [1:0] OFS_NEG  = 2'd0;
	localparam logic [1:0] OFS_ZERO = 2'd1;
	localparam logic [1:0] OFS_POS  = 2'd2;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} root_state_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [LIDX_W-1:0]  idx;
	} cand_t;

	// Elaboration-time floor square root.
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] t;
		res = '0;
		for (int b = 31; b >= 0; b--) begin
			t = res | (64'd1 << b);
			if (t * t <= v) begin
				res = t;
			end
		end
		return res;
	endfunction

	localparam logic [SCORE_W-1:0] STRAIGHT_COST = SCORE_W'(64'd1 << FRAC_BITS);
	localparam logic [SCORE_W-1:0] DIAG_COST =
		SCORE_W'(isqrt64(64'd2 << (2 * FRAC_BITS)));

	// Lanes in scan order: x outer, y inner, center skipped.
	function automatic logic [1:0] lane_dx(input logic [LIDX_W-1:0] i);
		logic [1:0] c;
		case (i)
			3'd0, 3'd1, 3'd2: c = OFS_NEG;
			3'd3, 3'd4:       c = OFS_ZERO;
			default:          c = OFS_POS;
		endcase
		return c;
	endfunction

	function automatic logic [1:0] lane_dy(input logic [LIDX_W-1:0] i);
		logic [1:0] c;
		case (i)
			3'd0, 3'd3, 3'd5: c = OFS_NEG;
			3'd1, 3'd6:       c = OFS_ZERO;
			default:          c = OFS_POS;
		endcase
		return c;
	endfunction

	// One restoring square-root step: bring down a bit pair, try to subtract.
	function automatic root_state_t root_step(input root_state_t st, input logic [1:0] pair);
		root_state_t       o;
		logic [REM_W-1:0]  rem2;
		logic [REM_W-1:0]  trial;
		rem2  = {st.rem[REM_W-3:0], pair};
		trial = {1'b0, st.root, 2'b01};
		if (rem2 >= trial) begin
			o.rem  = rem2 - trial;
			o.root = {st.root[ROOT_W-2:0], 1'b1};
		end else begin
			o.rem  = rem2;
			o.root = {st.root[ROOT_W-2:0], 1'b0};
		end
		return o;
	endfunction

endpackage
`default_nettype wire

// ----- design/greedy_grid_path_step_unit.sv -----
// Top level of the greedy best-first grid step unit (Euclidean metric).
`default_nettype none
// Takes a current grid point and a goal point and returns the neighbor of
// the current point with the lowest score, step cost (1.0 straight, sqrt2
// diagonal, 16 fraction bits) plus floor distance to the goal, together with
// a flag that is high when that neighbor is the goal. Ties keep the first
// neighbor in x-major, y-minor ascending order. A neighbor one step outside
// the coordinate range wraps in next_x/next_y and never reports arrived.
// Throughput is one item per clock while the receiver does not stall; the
// pipeline depth is set by the eight lanes of bit-per-stage square root
// units. Every stage has its own valid bit and moves whenever the stage after
// it is empty or moving, so bubbles close up and a stalled result does not
// block items entering behind it until the pipe is full.
module greedy_grid_path_step_unit (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  req_valid,
	output logic                                       req_stall,
	input  wire logic signed [ggps_pkg::COORD_BITS-1:0] cur_x,
	input  wire logic signed [ggps_pkg::COORD_BITS-1:0] cur_y,
	input  wire logic signed [ggps_pkg::COORD_BITS-1:0] goal_x,
	input  wire logic signed [ggps_pkg::COORD_BITS-1:0] goal_y,
	output logic                                       rsp_valid,
	input  wire logic                                  rsp_stall,
	output logic signed [ggps_pkg::COORD_BITS-1:0]      next_x,
	output logic signed [ggps_pkg::COORD_BITS-1:0]      next_y,
	output logic                                       arrived
);

	localparam int CB       = ggps_pkg::COORD_BITS;
	localparam int ST_ABS   = 0;
	localparam int ST_SUM   = 1;
	localparam int ST_ROOT  = 2;
	localparam int ST_SCORE = ST_ROOT + ggps_pkg::ROOT_W;
	localparam int ST_M1    = ST_SCORE + 1;
	localparam int ST_M2    = ST_M1 + 1;
	localparam int ST_OUT   = ST_M2 + 1;
	localparam int NST      = ST_OUT + 1;

	// ---- stage handshake: per-stage valid, ready chain from the output ----
	logic [NST-1:0] vld_q;
	logic [NST:0]   rdy;
	logic [NST-1:0] ld;

	assign rdy[NST] = !rsp_stall;
	for (genvar k = 0; k < NST; k++) begin : g_ctl
		assign rdy[k] = !vld_q[k] || rdy[k+1];
		if (k == 0) begin : g_first
			assign ld[k] = rdy[k] && req_valid;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_q[k] <= 1'b0;
				end else if (rdy[k]) begin
					vld_q[k] <= req_valid;
				end
			end
		end else begin : g_rest
			assign ld[k] = rdy[k] && vld_q[k-1];
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_q[k] <= 1'b0;
				end else if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign req_stall = !rdy[0];
	assign rsp_valid = vld_q[ST_OUT];

	// ---- coordinates travel alongside up to the output stage ----
	logic [CB-1:0] cx_s [ST_OUT];
	logic [CB-1:0] cy_s [ST_OUT];
	logic [CB-1:0] gx_s [ST_OUT];
	logic [CB-1:0] gy_s [ST_OUT];

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			cx_s[0] <= cur_x;
			cy_s[0] <= cur_y;
			gx_s[0] <= goal_x;
			gy_s[0] <= goal_y;
		end
	end
	for (genvar k = 1; k < ST_OUT; k++) begin : g_coord
		always_ff @(posedge clk) begin
			if (ld[k]) begin
				cx_s[k] <= cx_s[k-1];
				cy_s[k] <= cy_s[k-1];
				gx_s[k] <= gx_s[k-1];
				gy_s[k] <= gy_s[k-1];
			end
		end
	end

	// ---- stage 1: per-axis distance magnitudes for offsets -1, 0, +1 ----
	logic [ggps_pkg::MAG_W-1:0] ax_s1 [3];
	logic [ggps_pkg::MAG_W-1:0] ay_s1 [3];

	for (genvar i = 0; i < 3; i++) begin : g_abs
		logic signed [ggps_pkg::DIFF_W-1:0] ex;
		logic signed [ggps_pkg::DIFF_W-1:0] ey;
		logic signed [ggps_pkg::DIFF_W-1:0] ofs;
		// goal - (cur + d) = goal - cur + (-d), d = i - 1
		assign ofs = $signed(ggps_pkg::DIFF_W'(1 - i));
		assign ex  = $signed({{2{goal_x[CB-1]}}, goal_x})
		           - $signed({{2{cur_x[CB-1]}}, cur_x}) + ofs;
		assign ey  = $signed({{2{goal_y[CB-1]}}, goal_y})
		           - $signed({{2{cur_y[CB-1]}}, cur_y}) + ofs;
		always_ff @(posedge clk) begin
			if (ld[ST_ABS]) begin
				ax_s1[i] <= ex[ggps_pkg::DIFF_W-1] ? ggps_pkg::MAG_W'(-ex)
				                                   : ggps_pkg::MAG_W'(ex);
				ay_s1[i] <= ey[ggps_pkg::DIFF_W-1] ? ggps_pkg::MAG_W'(-ey)
				                                   : ggps_pkg::MAG_W'(ey);
			end
		end
	end

	// ---- stage 2: squared distance per lane ----
	logic [ggps_pkg::SUM_W-1:0]  ssum_s2 [ggps_pkg::LANES];
	logic [ggps_pkg::ROOT_W-1:0] root    [ggps_pkg::LANES];
	logic [ggps_pkg::SCORE_W-1:0] score_s [ggps_pkg::LANES];

	for (genvar l = 0; l < ggps_pkg::LANES; l++) begin : g_lane
		localparam logic [1:0] DXC = ggps_pkg::lane_dx(ggps_pkg::LIDX_W'(l));
		localparam logic [1:0] DYC = ggps_pkg::lane_dy(ggps_pkg::LIDX_W'(l));
		localparam bit DIAG = (DXC != ggps_pkg::OFS_ZERO) && (DYC != ggps_pkg::OFS_ZERO);
		logic [ggps_pkg::MAG_W-1:0] ax;
		logic [ggps_pkg::MAG_W-1:0] ay;
		assign ax = ax_s1[DXC];
		assign ay = ay_s1[DYC];

		always_ff @(posedge clk) begin
			if (ld[ST_SUM]) begin
				ssum_s2[l] <= ggps_pkg::SUM_W'(ax * ax) + ggps_pkg::SUM_W'(ay * ay);
			end
		end

		ggps_isqrt u_isqrt (
			.clk  (clk),
			.en   (ld[ST_ROOT +: ggps_pkg::ROOT_W]),
			.s    (ssum_s2[l]),
			.root (root[l])
		);

		always_ff @(posedge clk) begin
			if (ld[ST_SCORE]) begin
				score_s[l] <= ggps_pkg::SCORE_W'(root[l])
				            + (DIAG ? ggps_pkg::DIAG_COST : ggps_pkg::STRAIGHT_COST);
			end
		end
	end

	// ---- min tree: the later candidate wins only when strictly lower ----
	function automatic ggps_pkg::cand_t pick(input ggps_pkg::cand_t a, input ggps_pkg::cand_t b);
		return (b.score < a.score) ? b : a;
	endfunction

	ggps_pkg::cand_t m1_s [4];
	ggps_pkg::cand_t m2_s [2];

	for (genvar p = 0; p < 4; p++) begin : g_m1
		always_ff @(posedge clk) begin
			if (ld[ST_M1]) begin
				m1_s[p] <= pick('{score: score_s[2*p],   idx: ggps_pkg::LIDX_W'(2*p)},
				                '{score: score_s[2*p+1], idx: ggps_pkg::LIDX_W'(2*p+1)});
			end
		end
	end
	for (genvar p = 0; p < 2; p++) begin : g_m2
		always_ff @(posedge clk) begin
			if (ld[ST_M2]) begin
				m2_s[p] <= pick(m1_s[2*p], m1_s[2*p+1]);
			end
		end
	end

	// ---- output stage: final pick, neighbor coordinates, arrival check ----
	ggps_pkg::cand_t            best;
	logic signed [CB:0]         nx;
	logic signed [CB:0]         ny;
	logic signed [CB:0]         cxe;
	logic signed [CB:0]         cye;

	assign best = pick(m2_s[0], m2_s[1]);
	assign cxe  = $signed({cx_s[ST_M2][CB-1], cx_s[ST_M2]});
	assign cye  = $signed({cy_s[ST_M2][CB-1], cy_s[ST_M2]});

	always_comb begin
		case (ggps_pkg::lane_dx(best.idx))
			ggps_pkg::OFS_NEG:  nx = cxe - (CB+1)'(1);
			ggps_pkg::OFS_ZERO: nx = cxe;
			default:            nx = cxe + (CB+1)'(1);
		endcase
		case (ggps_pkg::lane_dy(best.idx))
			ggps_pkg::OFS_NEG:  ny = cye - (CB+1)'(1);
			ggps_pkg::OFS_ZERO: ny = cye;
			default:            ny = cye + (CB+1)'(1);
		endcase
	end

	logic [CB-1:0] next_x_q;
	logic [CB-1:0] next_y_q;
	logic          arrived_q;

	always_ff @(posedge clk) begin
		if (ld[ST_OUT]) begin
			next_x_q  <= nx[CB-1:0];
			next_y_q  <= ny[CB-1:0];
			// exact compare: a wrapped neighbor never matches the goal
			arrived_q <= (nx == $signed({gx_s[ST_M2][CB-1], gx_s[ST_M2]}))
			          && (ny == $signed({gy_s[ST_M2][CB-1], gy_s[ST_M2]}));
		end
	end

	assign next_x  = next_x_q;
	assign next_y  = next_y_q;
	assign arrived = arrived_q;

endmodule
`default_nettype wire

// ----- design/ggps_isqrt.sv -----
// Pipelined floor square root of (s << 2*FRAC_BITS), one root bit per stage.
`default_nettype none
module ggps_isqrt (
	input  wire logic                        clk,
	input  wire logic [ggps_pkg::ROOT_W-1:0] en,
	input  wire logic [ggps_pkg::SUM_W-1:0]  s,
	output logic      [ggps_pkg::ROOT_W-1:0] root
);

	ggps_pkg::root_state_t            st_s  [ggps_pkg::ROOT_W];
	logic [ggps_pkg::SUM_W-1:0]       rad_s [ggps_pkg::ROOT_W];

	// Stage 0 starts from an empty remainder.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			st_s[0]  <= ggps_pkg::root_step('0, s[ggps_pkg::SUM_W-1 -: 2]);
			rad_s[0] <= {s[ggps_pkg::SUM_W-3:0], 2'b00};
		end
	end

	for (genvar j = 1; j < ggps_pkg::ROOT_W; j++) begin : g_step
		always_ff @(posedge clk) begin
			if (en[j]) begin
				// zeros shift in once the radicand bits are used up
				st_s[j]  <= ggps_pkg::root_step(st_s[j-1],
					rad_s[j-1][ggps_pkg::SUM_W-1 -: 2]);
				rad_s[j] <= {rad_s[j-1][ggps_pkg::SUM_W-3:0], 2'b00};
			end
		end
	end

	assign root = st_s[ggps_pkg::ROOT_W-1].root;

endmodule
`default_nettype wire

// ----- test/tb_greedy_grid_path_step_unit.sv -----
// Testbench for the greedy grid path step unit: directed table, a stalled burst and random walks.
`default_nettype none
module tb_greedy_grid_path_step_unit;

	localparam int CB        = ggps_pkg::COORD_BITS;
	localparam int LATENCY   = ggps_pkg::ROOT_W + 6;
	localparam int N_RANDOM  = 1600;
	localparam int MAX_CYC   = 400000;

	typedef logic signed [CB-1:0] coord_t;

	typedef struct {
		coord_t cx, cy, gx, gy;
		logic   known;   // expected result typed in
		coord_t nx, ny;
		logic   arr;
	} stim_row_t;

	typedef struct {
		coord_t nx, ny;
		logic   arr;
	} step_t;

	logic   clk, arst_n;
	logic   req_valid, req_stall, rsp_valid, rsp_stall, arrived;
	coord_t cur_x, cur_y, goal_x, goal_y, next_x, next_y;

	step_t  pending_steps[$];
	int     errors;
	longint cycle;
	logic   hold_off;   // long receiver stall requested by stimulus

	greedy_grid_path_step_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.cur_x(cur_x), .cur_y(cur_y), .goal_x(goal_x), .goal_y(goal_y),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.next_x(next_x), .next_y(next_y), .arrived(arrived)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Floor square root of a 128-bit value, two bits per step.
	function automatic logic [63:0] floor_root(input logic [127:0] v);
		logic [65:0] rem;
		logic [65:0] trial;
		logic [63:0] root;
		rem  = '0;
		root = '0;
		for (int k = 63; k >= 0; k--) begin
			rem   = {rem[63:0], v[2*k+1 -: 2]};
			trial = {root, 2'b01};
			if (rem >= trial) begin
				rem  = rem - trial;
				root = {root[62:0], 1'b1};
			end else begin
				root = {root[62:0], 1'b0};
			end
		end
		return root;
	endfunction

	// Best neighbor by step cost plus scaled Euclidean distance.
	function automatic step_t best_neighbor(input coord_t cx, cy, gx, gy);
		step_t       r;
		logic [63:0] straight, diag, score, best;
		longint      nx, ny, ddx, ddy, bx, by;
		logic        have;
		straight = 64'd1 << ggps_pkg::FRAC_BITS;
		diag     = floor_root(128'd2 << (2 * ggps_pkg::FRAC_BITS));
		have     = 1'b0;
		best     = '0;
		bx       = cx;
		by       = cy;
		for (int dx = -1; dx <= 1; dx++) begin
			for (int dy = -1; dy <= 1; dy++) begin
				if (dx != 0 || dy != 0) begin
					nx    = longint'(cx) + dx;
					ny    = longint'(cy) + dy;
					ddx   = longint'(gx) - nx;
					ddy   = longint'(gy) - ny;
					score = ((dx != 0 && dy != 0) ? diag : straight)
						+ floor_root(128'(ddx * ddx + ddy * ddy)
							<< (2 * ggps_pkg::FRAC_BITS));
					if (!have || score < best) begin
						have = 1'b1;
						best = score;
						bx   = nx;
						by   = ny;
					end
				end
			end
		end
		r.nx  = coord_t'(bx);
		r.ny  = coord_t'(by);
		r.arr = (bx == longint'(gx)) && (by == longint'(gy));
		return r;
	endfunction

	// Drive one item and wait for acceptance; predicted or typed-in result queued.
	// valid drops only for an idle gap; the caller drops it after the last item.
	task automatic send_step(input coord_t cx, cy, gx, gy, input logic known,
			input step_t typed);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		cur_x     <= cx;
		cur_y     <= cy;
		goal_x    <= gx;
		goal_y    <= gy;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pending_steps.push_back(known ? typed : best_neighbor(cx, cy, gx, gy));
	endtask

	function automatic coord_t rnd_coord();
		return coord_t'($urandom);
	endfunction

	// Receiver: random stall per item; long hold-off when asked.
	initial begin
		int wait_cyc;
		rsp_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				rsp_stall <= 1'b1;
				repeat (200) @(posedge clk);
				hold_off = 1'b0;
			end
			wait_cyc = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 16);
			if (wait_cyc > 0) begin
				rsp_stall <= 1'b1;
				repeat (wait_cyc) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
		end
	end

	// Checker samples at the edge: accepted result compared with oldest expectation.
	always @(posedge clk) begin
		step_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_steps.size() == 0) begin
				$error("result with nothing expected: next_x=%0d next_y=%0d", next_x, next_y);
				errors++;
			end else begin
				e = pending_steps.pop_front();
				if (next_x !== e.nx) begin
					$error("next_x expected %0d actual %0d", e.nx, next_x);
					errors++;
				end
				if (next_y !== e.ny) begin
					$error("next_y expected %0d actual %0d", e.ny, next_y);
					errors++;
				end
				if (arrived !== e.arr) begin
					$error("arrived expected %0d actual %0d", e.arr, arrived);
					errors++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle++;
		if (cycle > MAX_CYC) begin
			$display("** greedy_grid_path_step_unit: FAILED **");
			$finish;
		end
	end

	stim_row_t dir_rows[$];

	function automatic stim_row_t mk(input int cx, cy, gx, gy, input logic k = 1'b0,
			input int nx = 0, ny = 0, input logic a = 1'b0);
		stim_row_t r;
		r.cx = coord_t'(cx); r.cy = coord_t'(cy);
		r.gx = coord_t'(gx); r.gy = coord_t'(gy);
		r.known = k;
		r.nx = coord_t'(nx); r.ny = coord_t'(ny); r.arr = a;
		return r;
	endfunction

	initial begin
		step_t  typed;
		coord_t wx, wy, gx, gy;
		int     sent, walk_len;
		step_t  s;
		errors    = 0;
		cycle     = 0;
		hold_off  = 1'b0;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		cur_x = '0; cur_y = '0; goal_x = '0; goal_y = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: one-step arrivals, goal equal current, range edges, ties.
		dir_rows.push_back(mk(0, 0, 1, 0, 1'b1, 1, 0, 1'b1));
		dir_rows.push_back(mk(0, 0, 1, 1, 1'b1, 1, 1, 1'b1));
		dir_rows.push_back(mk(0, 0, -1, -1, 1'b1, -1, -1, 1'b1));
		dir_rows.push_back(mk(5, 5, 5, 6, 1'b1, 5, 6, 1'b1));
		dir_rows.push_back(mk(0, 0, 0, 0));           // goal equals current
		dir_rows.push_back(mk(-512, -512, -512, -512));
		dir_rows.push_back(mk(511, 511, 511, 511));
		dir_rows.push_back(mk(-512, -512, 511, 511));
		dir_rows.push_back(mk(511, 511, -512, -512));
		dir_rows.push_back(mk(-512, 511, 511, -512));
		dir_rows.push_back(mk(511, -512, -512, 511));
		dir_rows.push_back(mk(511, 0, -512, 0));      // wrap candidates
		dir_rows.push_back(mk(0, -512, 0, 511));
		dir_rows.push_back(mk(0, 0, 10, 3));
		dir_rows.push_back(mk(0, 0, 3, 10));
		dir_rows.push_back(mk(0, 0, 2, 1));           // near-tie region
		dir_rows.push_back(mk(-341, 170, 170, -341));
		dir_rows.push_back(mk(100, -100, 100, -102));
		foreach (dir_rows[i]) begin
			typed.nx = dir_rows[i].nx; typed.ny = dir_rows[i].ny; typed.arr = dir_rows[i].arr;
			send_step(dir_rows[i].cx, dir_rows[i].cy, dir_rows[i].gx, dir_rows[i].gy,
				dir_rows[i].known, typed);
		end
		req_valid <= 1'b0;

		// Pause until drained.
		while (pending_steps.size() != 0) @(posedge clk);

		// Burst under a long receiver hold-off so the pipe fills and stalls input.
		hold_off = 1'b1;
		repeat (60) begin
			req_valid <= 1'b1;
			cur_x <= rnd_coord(); cur_y <= rnd_coord();
			goal_x <= rnd_coord(); goal_y <= rnd_coord();
			@(posedge clk);
			while (req_stall) @(posedge clk);
			pending_steps.push_back(best_neighbor(cur_x, cur_y, goal_x, goal_y));
		end

		// Random: mostly short walks toward a nearby goal, fed back; some noise.
		sent = 0;
		while (sent < N_RANDOM) begin
			if ($urandom_range(0, 4) == 0) begin
				send_step(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), 1'b0, typed);
				sent++;
			end else begin
				wx = rnd_coord(); wy = rnd_coord();
				gx = coord_t'(wx + $signed($urandom_range(0, 16)) - 8);
				gy = coord_t'(wy + $signed($urandom_range(0, 16)) - 8);
				walk_len = $urandom_range(2, 12);
				for (int k = 0; k < walk_len; k++) begin
					send_step(wx, wy, gx, gy, 1'b0, typed);
					s  = best_neighbor(wx, wy, gx, gy);
					wx = s.nx;
					wy = s.ny;
					sent++;
				end
			end
		end
		req_valid <= 1'b0;

		while (pending_steps.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0)
			$display("** greedy_grid_path_step_unit: PASSED **");
		else
			$display("** greedy_grid_path_step_unit: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire
